// File: rtl/png_hcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG header and chunk validator package
// Shared constants, codes and helper functions for the PNG validator.
// ----------------------------------------------------------------------------
package png_hcv_pkg;

	// Result status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_HEADER = 2'd1;
	localparam logic [1:0] ST_BAD_CHUNK  = 2'd2;
	localparam logic [1:0] ST_TOO_LONG   = 2'd3;

	// Failure codes kept while a file streams in.
	localparam logic [1:0] FAIL_NONE   = 2'd0;
	localparam logic [1:0] FAIL_HEADER = 2'd1;
	localparam logic [1:0] FAIL_CHUNK  = 2'd2;

	// Parser phases.
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LEN    = 3'd1;
	localparam logic [2:0] PH_TYPE   = 3'd2;
	localparam logic [2:0] PH_BODY   = 3'd3;
	localparam logic [2:0] PH_CRC    = 3'd4;
	localparam logic [2:0] PH_ENDED  = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_FILE_BYTES = 2'd0;
	localparam logic [1:0] REG_MAX_PIXELS     = 2'd1;
	localparam logic [1:0] REG_HEADER_ONLY    = 2'd2;

	localparam logic [29:0] MAX_FILE_BYTES_RST = 30'd536870912;
	localparam logic [31:0] MAX_PIXELS_RST     = 32'd100000000;

	localparam logic [29:0] OFFSET_MAX   = 30'h3FFF_FFFF;
	localparam logic [30:0] HEADER_BYTES = 31'd33;

	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

	localparam logic [31:0] DIM_MAX = 32'h7FFF_FFFF;

	typedef logic [7:0] byte_arr_t [16];

	// Signature followed by the IHDR length and type.
	localparam byte_arr_t LEAD_BYTES = '{
		8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10,
		8'd0, 8'd0, 8'd0, 8'd13, 8'd73, 8'd72, 8'd68, 8'd82
	};

	// Reflected CRC-32 update over one byte, fully unrolled.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	// Legal bit depth for a given color type.
	function automatic logic depth_ok(input logic [7:0] color, input logic [7:0] depth);
		logic low_depth;
		logic ok;
		low_depth = (depth == 8'd1) || (depth == 8'd2) || (depth == 8'd4) || (depth == 8'd8);
		case (color)
			8'd0: ok = low_depth || (depth == 8'd16);
			8'd3: ok = low_depth;
			8'd2, 8'd4, 8'd6: ok = (depth == 8'd8) || (depth == 8'd16);
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// File: rtl/png_header_and_chunk_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG header and chunk validator core
// Checks a PNG byte stream: signature, IHDR fields and CRC, then the chunk
// structure up to IEND, and reports one verdict on the final byte.
// ----------------------------------------------------------------------------
//
// Channel | Signals                                   | Transfer when
// --------+-------------------------------------------+-----------------------
// in      | in_valid, in_ready, data_byte, last_byte  | in_valid & in_ready
// out     | out_valid, out_ready, status, image_*     | out_valid & out_ready
// config  | psel, penable, pwrite, paddr, pwdata, ... | psel & penable & pwrite
//
// One byte per cycle is sustained while no final byte waits on a stalled output.
// A byte is held in the input register, and its verdict (final byte only) is
// loaded from there into the output register once that register has room.
// The width times height product is registered from the captured IHDR fields
// and is ready long before the last IHDR byte. Reset clears all stream state but the product.
// A stalled output holds back only a final byte; other bytes keep flowing.
//
module png_header_and_chunk_validator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [30:0] image_width,
	output logic [30:0] image_height,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	logic [29:0] max_file_bytes_q;
	logic [31:0] max_pixels_q;
	logic        header_only_q;

	// Input register.
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	// Stream state.
	logic [29:0] offset_q, offset_n;
	logic [31:0] crc_q, crc_n;
	logic [31:0] width_q, width_n;
	logic [31:0] height_q, height_n;
	logic [7:0]  depth_q, depth_n;
	logic [7:0]  color_q, color_n;
	logic [31:0] stored_crc_q, stored_crc_n;
	logic [31:0] chunk_len_q, chunk_len_n;
	logic [31:0] chunk_pos_q, chunk_pos_n;
	logic [31:0] chunk_type_q, chunk_type_n;
	logic [2:0]  phase_q, phase_n;
	logic        seen_q, seen_n;
	logic [1:0]  fail_q, fail_n;
	logic [63:0] area_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  status_q, status_n;
	logic [30:0] out_width_q, out_width_n;
	logic [30:0] out_height_q, out_height_n;

	logic        advance;
	logic        cfg_write;
	logic [30:0] total;
	logic [31:0] pos_inc;

	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_comb begin
		case (paddr[3:2])
			png_hcv_pkg::REG_MAX_FILE_BYTES: prdata = {2'd0, max_file_bytes_q};
			png_hcv_pkg::REG_MAX_PIXELS:     prdata = max_pixels_q;
			png_hcv_pkg::REG_HEADER_ONLY:    prdata = {31'd0, header_only_q};
			default:                         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_file_bytes_q <= png_hcv_pkg::MAX_FILE_BYTES_RST;
			max_pixels_q     <= png_hcv_pkg::MAX_PIXELS_RST;
			header_only_q    <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				png_hcv_pkg::REG_MAX_FILE_BYTES: max_file_bytes_q <= pwdata[29:0];
				png_hcv_pkg::REG_MAX_PIXELS:     max_pixels_q     <= pwdata;
				png_hcv_pkg::REG_HEADER_ONLY:    header_only_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// A non-final byte never needs room in the output register.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign total   = {1'b0, offset_q} + 31'd1;
	assign pos_inc = chunk_pos_q + 32'd1;

	always_comb begin
		offset_n     = offset_q;
		crc_n        = crc_q;
		width_n      = width_q;
		height_n     = height_q;
		depth_n      = depth_q;
		color_n      = color_q;
		stored_crc_n = stored_crc_q;
		chunk_len_n  = chunk_len_q;
		chunk_pos_n  = chunk_pos_q;
		chunk_type_n = chunk_type_q;
		phase_n      = phase_q;
		seen_n       = seen_q;
		fail_n       = fail_q;
		status_n     = png_hcv_pkg::ST_OK;
		out_width_n  = 31'd0;
		out_height_n = 31'd0;

		if (advance) begin
			if (phase_q == png_hcv_pkg::PH_HEADER) begin
				if (offset_q < 30'd33) begin
					if (offset_q < 30'd16 &&
					    data_s1 != png_hcv_pkg::LEAD_BYTES[offset_q[3:0]]) begin
						fail_n = png_hcv_pkg::FAIL_HEADER;
					end
					if (offset_q >= 30'd12 && offset_q <= 30'd28) begin
						crc_n = png_hcv_pkg::crc_byte(crc_q, data_s1);
					end
					if (offset_q >= 30'd16 && offset_q <= 30'd19) begin
						width_n = {width_q[23:0], data_s1};
					end else if (offset_q >= 30'd20 && offset_q <= 30'd23) begin
						height_n = {height_q[23:0], data_s1};
					end else if (offset_q == 30'd24) begin
						depth_n = data_s1;
					end else if (offset_q == 30'd25) begin
						color_n = data_s1;
					end else if ((offset_q == 30'd26 || offset_q == 30'd27) &&
					             data_s1 != 8'd0) begin
						fail_n = png_hcv_pkg::FAIL_HEADER;
					end else if (offset_q == 30'd28 && data_s1 > 8'd1) begin
						fail_n = png_hcv_pkg::FAIL_HEADER;
					end else if (offset_q >= 30'd29) begin
						stored_crc_n = {stored_crc_q[23:0], data_s1};
					end

					// The last CRC byte closes the header: the dimension, pixel-count, depth and CRC checks land here.
					if (offset_q == 30'd32) begin
						if (width_q == 32'd0 || height_q == 32'd0 ||
						    width_q > png_hcv_pkg::DIM_MAX ||
						    height_q > png_hcv_pkg::DIM_MAX ||
						    area_q > {32'd0, max_pixels_q} ||
						    !png_hcv_pkg::depth_ok(color_q, depth_q) ||
						    (crc_q ^ png_hcv_pkg::CRC_PRESET) != stored_crc_n) begin
							fail_n = png_hcv_pkg::FAIL_HEADER;
						end
						phase_n     = png_hcv_pkg::PH_LEN;
						chunk_pos_n = 32'd0;
						chunk_len_n = 32'd0;
					end
				end
			end else if (fail_q == png_hcv_pkg::FAIL_NONE) begin
				case (phase_q)
					png_hcv_pkg::PH_LEN: begin
						chunk_len_n = {chunk_len_q[23:0], data_s1};
						chunk_pos_n = pos_inc;
						if (pos_inc == 32'd4) begin
							phase_n      = png_hcv_pkg::PH_TYPE;
							chunk_pos_n  = 32'd0;
							chunk_type_n = 32'd0;
						end
					end
					png_hcv_pkg::PH_TYPE: begin
						chunk_type_n = {chunk_type_q[23:0], data_s1};
						chunk_pos_n  = pos_inc;
						if (pos_inc == 32'd4) begin
							chunk_pos_n = 32'd0;
							if (chunk_type_n == png_hcv_pkg::TYPE_IHDR) begin
								fail_n = png_hcv_pkg::FAIL_CHUNK;
							end
							if (chunk_type_n == png_hcv_pkg::TYPE_IDAT &&
							    chunk_len_q != 32'd0) begin
								seen_n = 1'b1;
							end
							if (chunk_type_n == png_hcv_pkg::TYPE_IEND &&
							    (!seen_q || chunk_len_q != 32'd0)) begin
								fail_n = png_hcv_pkg::FAIL_CHUNK;
							end
							phase_n = (chunk_len_q == 32'd0) ? png_hcv_pkg::PH_CRC
							                                 : png_hcv_pkg::PH_BODY;
						end
					end
					png_hcv_pkg::PH_BODY: begin
						chunk_pos_n = pos_inc;
						if (pos_inc == chunk_len_q) begin
							phase_n     = png_hcv_pkg::PH_CRC;
							chunk_pos_n = 32'd0;
						end
					end
					png_hcv_pkg::PH_CRC: begin
						chunk_pos_n = pos_inc;
						if (pos_inc == 32'd4) begin
							chunk_pos_n = 32'd0;
							if (chunk_type_q == png_hcv_pkg::TYPE_IEND) begin
								phase_n = png_hcv_pkg::PH_ENDED;
							end else begin
								phase_n     = png_hcv_pkg::PH_LEN;
								chunk_len_n = 32'd0;
							end
						end
					end
					default: begin
						// Anything after an accepted IEND is a trailing byte.
						fail_n = png_hcv_pkg::FAIL_CHUNK;
					end
				endcase
			end

			if (offset_q < png_hcv_pkg::OFFSET_MAX) begin
				offset_n = offset_q + 30'd1;
			end

			if (last_s1) begin
				if (total > {1'b0, max_file_bytes_q}) begin
					status_n = png_hcv_pkg::ST_TOO_LONG;
				end else if (fail_n == png_hcv_pkg::FAIL_HEADER ||
				             total < png_hcv_pkg::HEADER_BYTES) begin
					status_n = png_hcv_pkg::ST_BAD_HEADER;
				end else if (header_only_q) begin
					status_n = png_hcv_pkg::ST_OK;
				end else if (fail_n != png_hcv_pkg::FAIL_NONE ||
				             phase_n != png_hcv_pkg::PH_ENDED) begin
					status_n = png_hcv_pkg::ST_BAD_CHUNK;
				end else begin
					status_n = png_hcv_pkg::ST_OK;
				end
				if (status_n == png_hcv_pkg::ST_OK) begin
					out_width_n  = width_n[30:0];
					out_height_n = height_n[30:0];
				end

				// Back to the reset state for the next file.
				offset_n     = 30'd0;
				crc_n        = png_hcv_pkg::CRC_PRESET;
				width_n      = 32'd0;
				height_n     = 32'd0;
				depth_n      = 8'd0;
				color_n      = 8'd0;
				stored_crc_n = 32'd0;
				chunk_len_n  = 32'd0;
				chunk_pos_n  = 32'd0;
				chunk_type_n = 32'd0;
				phase_n      = png_hcv_pkg::PH_HEADER;
				seen_n       = 1'b0;
				fail_n       = png_hcv_pkg::FAIL_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= 30'd0;
			crc_q        <= png_hcv_pkg::CRC_PRESET;
			width_q      <= 32'd0;
			height_q     <= 32'd0;
			depth_q      <= 8'd0;
			color_q      <= 8'd0;
			stored_crc_q <= 32'd0;
			chunk_len_q  <= 32'd0;
			chunk_pos_q  <= 32'd0;
			chunk_type_q <= 32'd0;
			phase_q      <= png_hcv_pkg::PH_HEADER;
			seen_q       <= 1'b0;
			fail_q       <= png_hcv_pkg::FAIL_NONE;
		end else begin
			offset_q     <= offset_n;
			crc_q        <= crc_n;
			width_q      <= width_n;
			height_q     <= height_n;
			depth_q      <= depth_n;
			color_q      <= color_n;
			stored_crc_q <= stored_crc_n;
			chunk_len_q  <= chunk_len_n;
			chunk_pos_q  <= chunk_pos_n;
			chunk_type_q <= chunk_type_n;
			phase_q      <= phase_n;
			seen_q       <= seen_n;
			fail_q       <= fail_n;
		end
	end

	// Height is complete nine bytes before the header check reads the product.
	always_ff @(posedge clk) begin
		area_q <= {32'd0, width_q} * {32'd0, height_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q     <= status_n;
			out_width_q  <= out_width_n;
			out_height_q <= out_height_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign image_width  = out_width_q;
	assign image_height = out_height_q;

	// A new result only ever follows a final byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result produced without a final byte");

	// Leaving the header phase requires the whole header to have been seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != png_hcv_pkg::PH_HEADER |-> offset_q >= 30'd33)
		else $error("chunk walk started before end of header");

	// IEND is accepted only after pixel data.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == png_hcv_pkg::PH_ENDED |-> seen_q)
		else $error("ended phase without pixel data");

	// The final byte returns the stream state to its start.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> offset_q == 30'd0 && phase_q == png_hcv_pkg::PH_HEADER &&
		fail_q == png_hcv_pkg::FAIL_NONE)
		else $error("stream state not cleared after final byte");

	// A passing verdict always carries nonzero dimensions.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == png_hcv_pkg::ST_OK |->
		out_width_q != 31'd0 && out_height_q != 31'd0)
		else $error("ok status with zero dimension");

endmodule
